// File: design/rmts_pkg.sv
`timescale 1ns / 1ps

package rmts_pkg;

  localparam int MAX_TASKS_DEFAULT = 8;
  localparam int TIME_BITS_DEFAULT = 16;

  localparam int COUNT_W = 4;
  localparam int TABLE_W = 64;
  localparam int FIELD_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int TICK_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TASK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST_TABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TABLE = 2'd2;

  localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 4'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] phase;
    logic [FIELD_W-1:0] budget;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctl_t;

endpackage

// File: design/rmts_task_mem.sv
`timescale 1ns / 1ps

module rmts_task_mem #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT,
  parameter int IDX_W = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rmts_pkg::mem_ctl_t   ctl,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  rmts_pkg::entry_t     wr_data,
  output rmts_pkg::entry_t     rd_data
);

  rmts_pkg::entry_t mem [MAX_TASKS];
  rmts_pkg::entry_t rd_raw;
  logic [MAX_TASKS-1:0] written;
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // An entry that has not been written since reset or restart reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rd_ok <= written[rd_addr] && !ctl.clear;
      end
      if (ctl.clear) begin
        written <= '0;
      end else if (ctl.wr_en) begin
        written[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_ok ? rd_raw : '0;

endmodule

// File: design/rmts_sched.sv
`timescale 1ns / 1ps

module rmts_sched #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT,
  parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEFAULT,
  parameter int IDX_W = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rmts_pkg::COUNT_W-1:0]      task_count,
  input  logic [rmts_pkg::TABLE_W-1:0]      burst_table,
  input  logic [rmts_pkg::TABLE_W-1:0]      period_table,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rmts_pkg::TICK_W-1:0]       tick_time,
  output logic [rmts_pkg::COUNT_W-1:0]      task_number,
  output logic                              idle,
  output rmts_pkg::mem_ctl_t                ctl,
  output logic [IDX_W-1:0]                  rd_addr,
  output logic [IDX_W-1:0]                  wr_addr,
  output rmts_pkg::entry_t                  wr_data,
  input  rmts_pkg::entry_t                  rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic [TIME_BITS-1:0] time_q;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] winner;
  logic [rmts_pkg::FIELD_W:0] best;
  logic [rmts_pkg::FIELD_W-1:0] win_phase;
  logic [rmts_pkg::FIELD_W-1:0] win_budget;
  logic found;

  logic [rmts_pkg::COUNT_W-1:0] act;
  logic in_take;
  logic last;
  logic out_free;
  logic out_load;
  logic [rmts_pkg::FIELD_W-1:0] period;
  logic [rmts_pkg::FIELD_W-1:0] burst;
  logic [rmts_pkg::FIELD_W-1:0] budget_next;
  logic [rmts_pkg::FIELD_W-1:0] phase_next;
  logic candidate;

  assign act = (task_count > rmts_pkg::COUNT_W'(MAX_TASKS))
             ? rmts_pkg::COUNT_W'(MAX_TASKS) : task_count;
  assign in_stall = (state != S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign last = (rmts_pkg::COUNT_W'(idx) + 1'b1) == act;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_FINISH) && out_free;

  assign period = period_table[{idx, 3'b000} +: rmts_pkg::FIELD_W];
  assign burst = burst_table[{idx, 3'b000} +: rmts_pkg::FIELD_W];

  always_comb begin
    budget_next = rd_data.budget;
    phase_next = '0;
    candidate = 1'b0;
    if (period != '0) begin
      if (rd_data.phase == '0) begin
        budget_next = burst;
      end
      if ({1'b0, rd_data.phase} + 1'b1 < {1'b0, period}) begin
        phase_next = rd_data.phase + 1'b1;
      end
      candidate = (budget_next != '0) && ({1'b0, period} < best);
    end
  end

  always_comb begin
    ctl = '0;
    rd_addr = '0;
    wr_addr = idx;
    wr_data.phase = phase_next;
    wr_data.budget = budget_next;
    case (state)
      S_IDLE: begin
        ctl.clear = in_take && restart;
        ctl.rd_en = in_take && (act != '0);
      end
      S_SCAN: begin
        ctl.wr_en = 1'b1;
        ctl.rd_en = !last;
        rd_addr = idx + 1'b1;
      end
      S_FINISH: begin
        ctl.wr_en = found;
        wr_addr = winner;
        wr_data.phase = win_phase;
        wr_data.budget = win_budget - 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      time_q <= '0;
      found <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (restart) begin
              time_q <= '0;
            end
            found <= 1'b0;
            best <= {1'b1, {rmts_pkg::FIELD_W{1'b0}}};
            idx <= '0;
            state <= (act == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (candidate) begin
            best <= {1'b0, period};
            winner <= idx;
            win_phase <= phase_next;
            win_budget <= budget_next;
            found <= 1'b1;
          end
          if (last) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            tick_time <= rmts_pkg::TICK_W'(time_q);
            task_number <= found ? rmts_pkg::COUNT_W'(winner) + 1'b1 : '0;
            idle <= !found;
            time_q <= time_q + 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/rate_monotonic_tick_scheduler_unit.sv
`timescale 1ns / 1ps

// Rate monotonic tick scheduler. Each input transfer is one time tick; for
// each tick the block returns one result transfer with the tick time and the
// task that ran, or idle. A tick runs as a sequence of steps: accept the
// tick and start the first read, then one step for each active task slot
// (task_count capped at MAX_TASKS) as the per-task phase and budget memory
// is read, updated and written back, and a final step to retire the
// winner and load the output register. That last step waits as long as the
// output register still holds a stalled result. Configuration writes are taken
// at any time but must only be issued while no tick is in flight.
module rate_monotonic_tick_scheduler_unit #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT,
  parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rmts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rmts_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rmts_pkg::TICK_W-1:0]          tick_time,
  output logic [rmts_pkg::COUNT_W-1:0]         task_number,
  output logic                                 idle
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [rmts_pkg::COUNT_W-1:0] task_count;
  logic [rmts_pkg::TABLE_W-1:0] burst_table;
  logic [rmts_pkg::TABLE_W-1:0] period_table;

  rmts_pkg::mem_ctl_t ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  rmts_pkg::entry_t wr_data;
  rmts_pkg::entry_t rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= rmts_pkg::TASK_COUNT_RESET;
      burst_table <= '0;
      period_table <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmts_pkg::REG_TASK_COUNT: task_count <= cfg_data[rmts_pkg::COUNT_W-1:0];
        rmts_pkg::REG_BURST_TABLE: burst_table <= cfg_data;
        rmts_pkg::REG_PERIOD_TABLE: period_table <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rmts_sched #(
    .MAX_TASKS(MAX_TASKS),
    .TIME_BITS(TIME_BITS),
    .IDX_W(IDX_W)
  ) u_sched (
    .clk(clk),
    .rst(rst),
    .task_count(task_count),
    .burst_table(burst_table),
    .period_table(period_table),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tick_time(tick_time),
    .task_number(task_number),
    .idle(idle),
    .ctl(ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  rmts_task_mem #(
    .MAX_TASKS(MAX_TASKS),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

endmodule

// File: design/rmts_checker.sv
`timescale 1ns / 1ps

module rmts_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [rmts_pkg::TICK_W-1:0]       tick_time,
  input logic [rmts_pkg::COUNT_W-1:0]      task_number,
  input logic                              idle
);

  a_idle_no_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> task_number == '0)
    else $error("Idle result names a task.");

  a_busy_has_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && !idle |-> task_number != '0 && task_number <= 4'd8)
    else $error("Busy result has no valid task number.");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted while a tick is in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tick_time) && $stable(task_number))
    else $error("Stalled result changed.");

endmodule

bind rate_monotonic_tick_scheduler_unit rmts_checker u_rmts_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .tick_time(tick_time),
  .task_number(task_number),
  .idle(idle)
);

// File: tb/sv/tb_rate_monotonic_tick_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_rate_monotonic_tick_scheduler_unit;

  localparam int TOTAL_TICKS = 1850;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [rmts_pkg::TICK_W-1:0]  tick_time;
    logic [rmts_pkg::COUNT_W-1:0] task_number;
    logic                         idle;
  } tick_result_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rmts_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rmts_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             restart;
  logic                             out_valid;
  logic                             out_stall;
  logic [rmts_pkg::TICK_W-1:0]      tick_time;
  logic [rmts_pkg::COUNT_W-1:0]     task_number;
  logic                             idle;

  // Predictor state and configuration mirror.
  logic [rmts_pkg::COUNT_W-1:0]     cnt_cfg = rmts_pkg::TASK_COUNT_RESET;
  logic [rmts_pkg::TABLE_W-1:0]     burst_cfg = '0;
  logic [rmts_pkg::TABLE_W-1:0]     period_cfg = '0;
  logic [rmts_pkg::TICK_W-1:0]      model_time = '0;
  logic [rmts_pkg::FIELD_W-1:0]     sim_phase [8];
  logic [rmts_pkg::FIELD_W-1:0]     sim_budget [8];

  tick_result_t expected_ticks [$];
  tick_result_t head_tick;
  int mismatch_count = 0;
  int ticks_sent = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  bit hold_req = 1'b0;
  int stall_mode = 0;
  int stall_run = 0;

  rate_monotonic_tick_scheduler_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tick_time(tick_time),
    .task_number(task_number),
    .idle(idle)
  );

  always #5 clk = ~clk;

  function automatic tick_result_t schedule_tick(input logic rs);
    tick_result_t res;
    int active;
    int best;
    int winner;
    int per;
    bit found;
    if (rs) begin
      model_time = '0;
      for (int i = 0; i < 8; i++) begin
        sim_phase[i] = '0;
        sim_budget[i] = '0;
      end
    end
    active = (cnt_cfg > rmts_pkg::MAX_TASKS_DEFAULT)
           ? rmts_pkg::MAX_TASKS_DEFAULT : int'(cnt_cfg);
    best = 256;
    winner = 0;
    found = 1'b0;
    for (int i = 0; i < active; i++) begin
      per = int'(period_cfg[8*i +: 8]);
      if (per == 0) begin
        sim_phase[i] = '0;
        continue;
      end
      if (sim_phase[i] == 0) begin
        sim_budget[i] = burst_cfg[8*i +: 8];
      end
      if (int'(sim_phase[i]) + 1 >= per) begin
        sim_phase[i] = '0;
      end else begin
        sim_phase[i] = sim_phase[i] + 1'b1;
      end
      if (sim_budget[i] != 0 && per < best) begin
        best = per;
        winner = i;
        found = 1'b1;
      end
    end
    res.tick_time = model_time;
    if (found) begin
      sim_budget[winner] = sim_budget[winner] - 1'b1;
      res.task_number = rmts_pkg::COUNT_W'(winner + 1);
      res.idle = 1'b0;
    end else begin
      res.task_number = '0;
      res.idle = 1'b1;
    end
    model_time = model_time + 1'b1;
    return res;
  endfunction

  function automatic logic [rmts_pkg::TABLE_W-1:0] rand_table(input bit is_period);
    logic [rmts_pkg::TABLE_W-1:0] t;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      return {$urandom, $urandom};
    end
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        t[8*i +: 8] = 8'h00;
      end else if (r == 1) begin
        t[8*i +: 8] = 8'hFF;
      end else if (r == 2) begin
        t[8*i +: 8] = 8'($urandom_range(1, 255));
      end else begin
        t[8*i +: 8] = is_period ? 8'($urandom_range(1, 12)) : 8'($urandom_range(1, 6));
      end
    end
    return t;
  endfunction

  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_ticks.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rmts_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rmts_pkg::CFG_DATA_W-1:0] val);
    settle_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rmts_pkg::REG_TASK_COUNT: cnt_cfg = val[rmts_pkg::COUNT_W-1:0];
      rmts_pkg::REG_BURST_TABLE: burst_cfg = val;
      rmts_pkg::REG_PERIOD_TABLE: period_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_tick(input logic rs);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    restart = rs;
    do @(posedge clk); while (in_stall);
    expected_ticks.push_back(schedule_tick(rs));
    ticks_sent++;
  endtask

  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_release_and_priority();
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd8);
    write_reg(rmts_pkg::REG_BURST_TABLE, 64'hFF_02_00_FF_05_01_01_01);
    write_reg(rmts_pkg::REG_PERIOD_TABLE, 64'hFF_03_01_FF_00_02_02_04);
    repeat (8) send_tick(1'b0);
  endtask

  task automatic test_task_count_limits();
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd15);
    repeat (2) send_tick(1'b0);
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd0);
    repeat (2) send_tick(1'b0);
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd3);
    repeat (2) send_tick(1'b0);
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd8);
    send_tick(1'b0);
  endtask

  task automatic test_period_changes();
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd2);
    write_reg(rmts_pkg::REG_BURST_TABLE, 64'h00_00_00_00_00_00_05_05);
    write_reg(rmts_pkg::REG_PERIOD_TABLE, 64'h00_00_00_00_00_00_FF_FF);
    repeat (2) send_tick(1'b0);
    write_reg(rmts_pkg::REG_PERIOD_TABLE, 64'h00_00_00_00_00_00_00_02);
    repeat (2) send_tick(1'b0);
  endtask

  task automatic test_restart();
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
  endtask

  task automatic test_output_backpressure();
    write_reg(rmts_pkg::REG_TASK_COUNT, 64'd8);
    write_reg(rmts_pkg::REG_BURST_TABLE, 64'h03_02_01_04_02_03_01_02);
    write_reg(rmts_pkg::REG_PERIOD_TABLE, 64'h08_06_05_04_03_03_02_07);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_tick(1'b0);
  endtask

  task automatic test_random_schedules();
    int r;
    bit [2:0] mask;
    bit first;
    first = 1'b1;
    while (ticks_sent < TOTAL_TICKS) begin
      mask = first ? 3'b111 : 3'($urandom_range(1, 7));
      first = 1'b0;
      if (mask[0]) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          write_reg(rmts_pkg::REG_TASK_COUNT, 64'd0);
        end else if (r < 3) begin
          write_reg(rmts_pkg::REG_TASK_COUNT, 64'($urandom_range(9, 15)));
        end else begin
          write_reg(rmts_pkg::REG_TASK_COUNT, 64'($urandom_range(1, 8)));
        end
      end
      if (mask[1]) begin
        write_reg(rmts_pkg::REG_BURST_TABLE, rand_table(1'b0));
      end
      if (mask[2]) begin
        write_reg(rmts_pkg::REG_PERIOD_TABLE, rand_table(1'b1));
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      repeat ($urandom_range(20, 90)) send_tick($urandom_range(0, 29) == 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      sim_phase[i] = '0;
      sim_budget[i] = '0;
    end
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    restart = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_release_and_priority();
    test_task_count_limits();
    test_period_changes();
    test_restart();
    test_output_backpressure();
    test_random_schedules();

    settle_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The receiver alternates between free-running, light and heavy stall
  // patterns, and holds off completely when a long hold is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else begin
        if (stall_run == 0) begin
          stall_mode = $urandom_range(0, 2);
          stall_run = $urandom_range(5, 60);
        end
        stall_run--;
        case (stall_mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result transfer: time %0d task %0d idle %0b",
                   tick_time, task_number, idle);
        end
      end else begin
        head_tick = expected_ticks.pop_front();
        if (head_tick.tick_time !== tick_time || head_tick.task_number !== task_number ||
            head_tick.idle !== idle) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp time %0d task %0d idle %0b, got %0d %0d %0b",
                     head_tick.tick_time, head_tick.task_number, head_tick.idle,
                     tick_time, task_number, idle);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
